[sv/ashit_pkg.sv]
package ashit_pkg;

  // geometry and register widths
  localparam int unsigned RADIUS_W      = 12;
  localparam int unsigned SQ_W          = 2 * RADIUS_W;
  localparam int unsigned D2_W          = SQ_W + 1;
  localparam int unsigned SEG_W         = 8;
  localparam int unsigned GAP_W         = 16;
  localparam int unsigned GAP_PROD_W    = SEG_W + GAP_W;
  localparam int unsigned GAP_FRAC_BITS = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = 12'd4095;

  // cordic datapath
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned XY_W         = RADIUS_W + 1;
  localparam int unsigned PRESCALE     = 24;
  localparam int unsigned CORDIC_W     = XY_W + PRESCALE + 3;
  localparam int unsigned TURN_W       = 32;
  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_SEGMENTS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_RADIUS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_ANGLE    = 4'd3;

  localparam logic [SEG_W-1:0]    RST_NUM_SEGMENTS = 8'd8;
  localparam logic [RADIUS_W-1:0] RST_INNER_RADIUS = 12'd80;
  localparam logic [RADIUS_W-1:0] RST_OUTER_RADIUS = 12'd100;
  localparam logic [GAP_W-1:0]    RST_GAP_ANGLE    = 16'd0;

  // side information that rides along the angle pipeline
  typedef struct packed {
    logic ring_ok;
    logic zero_vec;
  } tag_t;

  // atan(2^-i) as a 32-bit fraction of a turn
  function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
    logic [TURN_W-1:0] r;
    unique case (idx)
      0:       r = 32'h20000000;
      1:       r = 32'h12E4051E;
      2:       r = 32'h09FB385B;
      3:       r = 32'h051111D4;
      4:       r = 32'h028B0D43;
      5:       r = 32'h0145D7E1;
      6:       r = 32'h00A2F61E;
      7:       r = 32'h00517C55;
      8:       r = 32'h0028BE53;
      9:       r = 32'h00145F2F;
      10:      r = 32'h000A2F98;
      11:      r = 32'h000517CC;
      12:      r = 32'h00028BE6;
      13:      r = 32'h000145F3;
      14:      r = 32'h0000A2FA;
      15:      r = 32'h0000517D;
      16:      r = 32'h000028BE;
      17:      r = 32'h0000145F;
      18:      r = 32'h00000A30;
      19:      r = 32'h00000518;
      20:      r = 32'h0000028C;
      21:      r = 32'h00000146;
      22:      r = 32'h000000A3;
      23:      r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/ashit_cordic.sv]
module ashit_cordic #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   vld_i,
  input  logic signed [ashit_pkg::XY_W-1:0]      x_i,
  input  logic signed [ashit_pkg::XY_W-1:0]      y_i,
  input  ashit_pkg::tag_t                        tag_i,
  output logic                                   vld_o,
  output logic [ANGLE_BITS-1:0]                  ang_o,
  output ashit_pkg::tag_t                        tag_o
);
  import ashit_pkg::*;

  localparam logic [TURN_W-1:0] ROUND_HALF = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);

  logic [CORDIC_STEPS:0]      vld_q;
  logic signed [CORDIC_W-1:0] x_q   [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_q   [0:CORDIC_STEPS];
  logic [TURN_W-1:0]          z_q   [0:CORDIC_STEPS];
  tag_t                       tag_q [0:CORDIC_STEPS];

  logic                  out_vld_q;
  logic [ANGLE_BITS-1:0] ang_q;
  tag_t                  out_tag_q;

  logic signed [CORDIC_W-1:0] x_pre, y_pre;
  logic [TURN_W-1:0]          z_round;

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[CORDIC_STEPS-1:0], vld_i};
      out_vld_q <= vld_q[CORDIC_STEPS];
    end
  end

  // prescale and fold the left half plane onto the right
  assign x_pre = CORDIC_W'(x_i) <<< PRESCALE;
  assign y_pre = CORDIC_W'(y_i) <<< PRESCALE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      if (x_i[XY_W-1]) begin
        x_q[0] <= -x_pre;
        y_q[0] <= -y_pre;
        z_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= x_pre;
        y_q[0] <= y_pre;
        z_q[0] <= '0;
      end
    end
  end

  // one vectoring micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[i+1] <= tag_q[i];
        if (!y_q[i][CORDIC_W-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end
      end
    end
  end

  // round half up to the output angle width, zero vector gives angle 0
  assign z_round = z_q[CORDIC_STEPS] + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_tag_q <= tag_q[CORDIC_STEPS];
      if (tag_q[CORDIC_STEPS].zero_vec) begin
        ang_q <= '0;
      end else begin
        ang_q <= z_round[TURN_W-1 -: ANGLE_BITS];
      end
    end
  end

  assign vld_o = out_vld_q;
  assign ang_o = ang_q;
  assign tag_o = out_tag_q;

endmodule

[sv/annular_sector_hit_test.sv]
// Classifies a query point against a ring split into a programmable number of
// equal segments around a centre point, one point per cycle unless the output
// stalls. The pipeline has three stages for the difference, the squared
// distance and the ring bounds, 26 stages of the pipelined CORDIC atan2
// (prescale, 24 micro-rotations, rounding), and three stages for the segment
// decision, the last of which is the output register. When the output beat is
// not taken the whole pipeline holds and in_ready_o drops. Configuration writes
// are always taken; the squared radii and the gap product follow a write in the
// cycle after it, so writes are expected while no beat is in flight.
module annular_sector_hit_test #(
  parameter int unsigned COORD_BITS         = 16,
  parameter int unsigned ANGLE_BITS         = 16,
  parameter int unsigned SEGMENT_INDEX_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ashit_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ashit_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // query points
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          center_x_i,
  input  logic signed [COORD_BITS-1:0]          center_y_i,
  input  logic signed [COORD_BITS-1:0]          point_x_i,
  input  logic signed [COORD_BITS-1:0]          point_y_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic [SEGMENT_INDEX_BITS-1:0]         segment_index_o
);
  import ashit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned EW = (DW > XY_W) ? DW : XY_W;
  localparam int unsigned PW = ANGLE_BITS + SEG_W;
  localparam int unsigned UW = ANGLE_BITS + 1;
  localparam int unsigned SW = ANGLE_BITS + GAP_FRAC_BITS + 9;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [UW-1:0]         FULL_U  = UW'(1) << ANGLE_BITS;
  localparam logic [SW-1:0]         LIMIT_E = SW'(1) << (ANGLE_BITS + GAP_FRAC_BITS);

  logic en;

  // configuration registers
  logic [SEG_W-1:0]      seg_count_q;
  logic [RADIUS_W-1:0]   inner_q, outer_q;
  logic [GAP_W-1:0]      gap_q;
  logic [SQ_W-1:0]       inner_sq_q, outer_sq_q;
  logic [GAP_PROD_W-1:0] gap_prod_q;

  // stage a: differences
  logic                  a_vld_q, a_far_q, a_zero_q;
  logic [RADIUS_W-1:0]   a_ax_q, a_ay_q;
  logic signed [XY_W-1:0] a_x_q, a_y_q;
  // stage b: squares
  logic                  b_vld_q, b_far_q, b_zero_q;
  logic [SQ_W-1:0]       b_sqx_q, b_sqy_q;
  logic signed [XY_W-1:0] b_x_q, b_y_q;
  // stage c: ring bounds
  logic                  c_vld_q;
  tag_t                  c_tag_q;
  logic signed [XY_W-1:0] c_x_q, c_y_q;
  // cordic output
  logic                  k_vld;
  logic [ANGLE_BITS-1:0] k_ang;
  tag_t                  k_tag;
  // stage d: scaled angle
  logic                  d_vld_q, d_ring_q;
  logic [PW-1:0]         d_prod_q;
  // stage e: offset from segment centre
  logic                  e_vld_q, e_ring_q;
  logic [UW-1:0]         e_u_q;
  logic [SEG_W-1:0]      e_idx_q;
  // stage f: output register
  logic                  f_vld_q, f_hit_q;
  logic [SEGMENT_INDEX_BITS-1:0] f_idx_q;

  // whole pipeline advances unless the output beat is stalled
  assign en          = !f_vld_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= RST_NUM_SEGMENTS;
      inner_q     <= RST_INNER_RADIUS;
      outer_q     <= RST_OUTER_RADIUS;
      gap_q       <= RST_GAP_ANGLE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NUM_SEGMENTS: seg_count_q <= cfg_data_i[SEG_W-1:0];
        REG_INNER_RADIUS: inner_q     <= cfg_data_i[RADIUS_W-1:0];
        REG_OUTER_RADIUS: outer_q     <= cfg_data_i[RADIUS_W-1:0];
        REG_GAP_ANGLE:    gap_q       <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // derived constants of the configuration
  always_ff @(posedge clk_i) begin
    inner_sq_q <= SQ_W'(inner_q) * SQ_W'(inner_q);
    outer_sq_q <= SQ_W'(outer_q) * SQ_W'(outer_q);
    gap_prod_q <= GAP_PROD_W'(seg_count_q) * GAP_PROD_W'(gap_q);
  end

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= k_vld;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  // stage a: vector from centre to point and its magnitude per axis
  logic signed [DW-1:0] dx_s, dy_s;
  logic signed [EW-1:0] dx_e, dy_e;
  logic [EW-1:0]        ax_e, ay_e;

  assign dx_s = DW'(point_x_i) - DW'(center_x_i);
  assign dy_s = DW'(point_y_i) - DW'(center_y_i);
  assign dx_e = EW'(dx_s);
  assign dy_e = EW'(dy_s);
  assign ax_e = dx_e[EW-1] ? EW'(-dx_e) : EW'(dx_e);
  assign ay_e = dy_e[EW-1] ? EW'(-dy_e) : EW'(dy_e);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_far_q  <= (ax_e > EW'(RADIUS_LIMIT)) || (ay_e > EW'(RADIUS_LIMIT));
      a_zero_q <= (dx_s == '0) && (dy_s == '0);
      a_ax_q   <= ax_e[RADIUS_W-1:0];
      a_ay_q   <= ay_e[RADIUS_W-1:0];
      a_x_q    <= dx_e[XY_W-1:0];
      a_y_q    <= dy_e[XY_W-1:0];
    end
  end

  // stage b: squares of the axis distances
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_far_q  <= a_far_q;
      b_zero_q <= a_zero_q;
      b_sqx_q  <= SQ_W'(a_ax_q) * SQ_W'(a_ax_q);
      b_sqy_q  <= SQ_W'(a_ay_q) * SQ_W'(a_ay_q);
      b_x_q    <= a_x_q;
      b_y_q    <= a_y_q;
    end
  end

  // stage c: inclusive ring bounds on the squared distance
  logic [D2_W-1:0] d2;
  assign d2 = D2_W'(b_sqx_q) + D2_W'(b_sqy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_tag_q.ring_ok  <= !b_far_q && (seg_count_q != '0) &&
                          (d2 >= D2_W'(inner_sq_q)) && (d2 <= D2_W'(outer_sq_q));
      c_tag_q.zero_vec <= b_zero_q;
      c_x_q            <= b_x_q;
      c_y_q            <= b_y_q;
    end
  end

  ashit_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (c_vld_q),
    .x_i    (c_x_q),
    .y_i    (c_y_q),
    .tag_i  (c_tag_q),
    .vld_o  (k_vld),
    .ang_o  (k_ang),
    .tag_o  (k_tag)
  );

  // stage d: angle from the gap centre, scaled by the segment count
  logic [ANGLE_BITS-1:0] rel;
  assign rel = k_ang + QUARTER;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ring_q <= k_tag.ring_ok;
      d_prod_q <= PW'(seg_count_q) * PW'(rel);
    end
  end

  // stage e: segment number and distance from its centre
  logic [SEG_W-1:0]      seg_k;
  logic [ANGLE_BITS-1:0] seg_f;
  logic [UW-1:0]         two_f;

  assign seg_k = d_prod_q[PW-1:ANGLE_BITS];
  assign seg_f = d_prod_q[ANGLE_BITS-1:0];
  assign two_f = {seg_f, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ring_q <= d_ring_q;
      e_u_q    <= seg_f[ANGLE_BITS-1] ? (two_f - FULL_U) : (FULL_U - two_f);
      // on a shared boundary the lower segment wins
      if ((seg_f == '0) && (seg_k != '0)) begin
        e_idx_q <= seg_k - SEG_W'(1);
      end else begin
        e_idx_q <= seg_k;
      end
    end
  end

  // stage f: compare against half the sweep less the gap
  logic [SW-1:0] excess;
  logic          hit;
  assign excess = (SW'(e_u_q) << GAP_FRAC_BITS) + (SW'(gap_prod_q) << ANGLE_BITS);
  assign hit    = e_ring_q && (excess <= LIMIT_E);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_hit_q <= hit;
      f_idx_q <= hit ? SEGMENT_INDEX_BITS'(e_idx_q) : '0;
    end
  end

  assign out_valid_o     = f_vld_q;
  assign hit_o           = f_hit_q;
  assign segment_index_o = f_idx_q;

endmodule

[sv/ashit_checker.sv]
module ashit_checker #(
  parameter int unsigned SEGMENT_INDEX_BITS = 8
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          hit_o,
  input logic [SEGMENT_INDEX_BITS-1:0] segment_index_o
);

  // a stalled result beat stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_o) && $stable(segment_index_o))
    else $error("result payload changed while stalled");

  // a stalled output freezes the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while output stalled");

  // a miss carries segment index zero
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> segment_index_o == '0)
    else $error("nonzero segment index on a miss");

endmodule

bind annular_sector_hit_test ashit_checker #(
  .SEGMENT_INDEX_BITS (SEGMENT_INDEX_BITS)
) u_ashit_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .segment_index_o (segment_index_o)
);

[tb/tb_annular_sector_hit_test.sv]
module tb_annular_sector_hit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ashit_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int COORD_W         = 16;
  localparam int ROTATIONS       = 24;
  localparam int FAR_COORD       = 4095;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 64;
  localparam int QUIET_LIMIT     = 2000;

  // write indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  // atan(2^-i) in 2^-32 turns
  localparam logic [31:0] ROTATION_TURNS [ROTATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic             hit;
    logic [SEG_W-1:0] segment;
  } hit_result_t;

  typedef struct {
    logic [SEG_W-1:0]    segments;
    logic [RADIUS_W-1:0] inner;
    logic [RADIUS_W-1:0] outer;
    logic [GAP_W-1:0]    gap;
  } ring_cfg_t;

  // directed rows: a write carries index and data in f0/f1, a point carries
  // center x/y and point x/y; ROW_MISS is a point that must plainly miss
  typedef enum logic [1:0] {ROW_WRITE, ROW_POINT, ROW_MISS} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] f0;
    logic [15:0] f1;
    logic [15:0] f2;
    logic [15:0] f3;
  } dir_row_t;

  localparam int NUM_ROWS = 38;
  localparam dir_row_t DIRECTED [NUM_ROWS] = '{
    // reset settings: 8 segments, ring 80..100, no gap
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd90, 16'sd0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd0, -16'sd90},
    '{ROW_MISS, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{ROW_MISS, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF},
    '{ROW_MISS, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000},
    '{ROW_POINT, 16'sd100, 16'sd100, 16'sd180, 16'sd100},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd0, 16'sd100},
    '{ROW_MISS, 16'sd0, 16'sd0, 16'sd0, 16'sd101},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd60, 16'sd60},
    '{ROW_POINT, 16'sd0, 16'sd0, -16'sd64, -16'sd64},
    '{ROW_MISS, 16'h8000, 16'sd0, 16'h8FFF, 16'sd0},
    // no segments at all
    '{ROW_WRITE, 16'(REG_NUM_SEGMENTS), 16'h0000, 16'h0, 16'h0},
    '{ROW_MISS, 16'sd0, 16'sd0, 16'sd90, 16'sd0},
    // largest ring radius, most segments, upper data bits dropped
    '{ROW_WRITE, 16'(REG_NUM_SEGMENTS), 16'h01FF, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_INNER_RADIUS), 16'hFFFF, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_OUTER_RADIUS), 16'hFFFF, 16'h0, 16'h0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd4095, 16'sd0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd0, -16'sd4095},
    '{ROW_MISS, 16'sd0, 16'sd0, -16'sd4095, -16'sd1},
    // inner above outer
    '{ROW_WRITE, 16'(REG_OUTER_RADIUS), 16'h0000, 16'h0, 16'h0},
    '{ROW_MISS, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    // gap wider than a segment
    '{ROW_WRITE, 16'(REG_INNER_RADIUS), 16'hF000, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_OUTER_RADIUS), 16'h0FFF, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_GAP_ANGLE), 16'hFFFF, 16'h0, 16'h0},
    '{ROW_MISS, 16'sd0, 16'sd0, 16'sd1, 16'sd1},
    // half of each segment is gap
    '{ROW_WRITE, 16'(REG_GAP_ANGLE), 16'h1000, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_NUM_SEGMENTS), 16'h0008, 16'h0, 16'h0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd1000, 16'sd0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd1000, -16'sd1000},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    // one segment, zero vector and short vectors
    '{ROW_WRITE, 16'(REG_NUM_SEGMENTS), 16'h0001, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_GAP_ANGLE), 16'h0000, 16'h0, 16'h0},
    '{ROW_POINT, 16'sd5, 16'sd5, 16'sd5, 16'sd5},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd0, -16'sd5},
    '{ROW_POINT, 16'sd0, 16'sd0, -16'sd3, 16'sd2},
    // writes to unused indexes leave the settings alone
    '{ROW_WRITE, 16'(REG_SPARE_FIRST), 16'h0000, 16'h0, 16'h0},
    '{ROW_WRITE, 16'(REG_SPARE_LAST), 16'hFFFF, 16'h0, 16'h0},
    '{ROW_POINT, 16'sd0, 16'sd0, 16'sd7, 16'sd7}
  };

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic signed [COORD_W-1:0]    center_x_i  = '0;
  logic signed [COORD_W-1:0]    center_y_i  = '0;
  logic signed [COORD_W-1:0]    point_x_i   = '0;
  logic signed [COORD_W-1:0]    point_y_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         hit_o;
  logic [SEG_W-1:0]             segment_index_o;

  ring_cfg_t   ring;
  hit_result_t expected_results [$];
  int unsigned mismatch_count = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_left   = 0;
  rx_mode_e    rx_mode   = RX_OPEN;
  int unsigned quiet_cycles = 0;

  annular_sector_hit_test u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .segment_index_o (segment_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // vectoring cordic, angle of (x, y) in 2^-32 turns
  function automatic logic [31:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint      xs;
    longint      ys;
    int          i;
    z = '0;
    if (x == 0 && y == 0) return '0;
    x = x * 16777216;
    y = y * 16777216;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ROTATION_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ROTATION_TURNS[i];
      end
    end
    return z;
  endfunction

  // which segment of the current ring holds the point, if any
  function automatic hit_result_t classify_point(logic signed [COORD_W-1:0] cx,
                                                 logic signed [COORD_W-1:0] cy,
                                                 logic signed [COORD_W-1:0] px,
                                                 logic signed [COORD_W-1:0] py);
    hit_result_t r;
    longint dx, dy, ax, ay, d2, n;
    longint ang, rel, seg_unit, turn_span, pos, sweep_lim, center, arc_off, i;
    r  = '0;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    n  = longint'(ring.segments);
    if (n == 0) return r;
    if (ax > FAR_COORD || ay > FAR_COORD) return r;
    d2 = ax * ax + ay * ay;
    if (d2 < longint'(ring.inner) * longint'(ring.inner) ||
        d2 > longint'(ring.outer) * longint'(ring.outer)) return r;
    // round to 16-bit turns, then measure from the gap at three quarters
    ang = ((longint'({32'd0, vector_angle(dx, dy)}) + 32768) >> 16) & 65535;
    rel = (ang + 16384) & 65535;
    // exact compare at 2^32 units per segment half
    seg_unit  = longint'(1) << 32;
    turn_span = 2 * n * seg_unit;
    pos       = 2 * n * (rel << 16);
    sweep_lim = seg_unit - n * (longint'(ring.gap) << 16);
    if (sweep_lim < 0) return r;
    for (i = 0; i < n; i++) begin
      center  = (2 * i + 1) * seg_unit;
      arc_off = pos + turn_span - center;
      if (arc_off >= turn_span) arc_off = arc_off - turn_span;
      if (arc_off > turn_span / 2) arc_off = turn_span - arc_off;
      if (arc_off <= sweep_lim) begin
        r.hit     = 1'b1;
        r.segment = i[SEG_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // one register write beat; valid stays up for a following write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_NUM_SEGMENTS: ring.segments = data[SEG_W-1:0];
      REG_INNER_RADIUS: ring.inner    = data[RADIUS_W-1:0];
      REG_OUTER_RADIUS: ring.outer    = data[RADIUS_W-1:0];
      REG_GAP_ANGLE:    ring.gap      = data[GAP_W-1:0];
      default: ;
    endcase
  endtask

  // one point beat; valid stays up for a following point
  task automatic offer_point(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy,
                             logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                             bit known_miss);
    in_valid_i <= 1'b1;
    center_x_i <= cx;
    center_y_i <= cy;
    point_x_i  <= px;
    point_y_i  <= py;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (known_miss) expected_results.push_back('0);
    else expected_results.push_back(classify_point(cx, cy, px, py));
  endtask

  // stimulus
  initial begin : stim
    dir_row_t            row;
    int                  r, phase, k, tries, gap_len, burst_left;
    int                  base_x, base_y, dx, dy, reach, sel;
    longint              d2;
    logic [SEG_W-1:0]    seg_v;
    logic [RADIUS_W-1:0] inner_v, outer_v;
    logic [GAP_W-1:0]    gap_v;

    ring.segments = RST_NUM_SEGMENTS;
    ring.inner    = RST_INNER_RADIUS;
    ring.outer    = RST_OUTER_RADIUS;
    ring.gap      = RST_GAP_ANGLE;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.kind == ROW_WRITE) begin
        in_valid_i <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
        write_reg(row.f0[CFG_IDX_W-1:0], row.f1);
      end else begin
        cfg_valid_i <= 1'b0;
        offer_point(row.f0, row.f1, row.f2, row.f3, row.kind == ROW_MISS);
      end
    end

    // random phases, each with its own ring settings
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      in_valid_i <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk_i);

      if (phase == 1) seg_v = 8'd255;
      else if (phase == 2) seg_v = 8'd1;
      else if (phase == NUM_PHASES - 1) seg_v = 8'($urandom_range(0, 255));
      else seg_v = 8'($urandom_range(2, 24));
      outer_v = (phase == 1) ? 12'd4095 :
                (phase == 0) ? 12'($urandom_range(8, 300)) : 12'($urandom_range(8, 4095));
      inner_v = (phase == 1) ? 12'd0 : 12'($urandom_range(0, outer_v));
      if (phase < 3) gap_v = '0;
      else if (phase == NUM_PHASES - 1) gap_v = 16'($urandom_range(0, 65535));
      else gap_v = 16'($urandom_range(0, 32768 / seg_v));

      write_reg(REG_NUM_SEGMENTS, {8'($urandom), seg_v});
      write_reg(REG_INNER_RADIUS, {4'($urandom), inner_v});
      write_reg(REG_SPARE_FIRST + 4'($urandom_range(0, 11)), 16'($urandom));
      write_reg(REG_OUTER_RADIUS, {4'($urandom), outer_v});
      write_reg(REG_GAP_ANGLE, gap_v);
      cfg_valid_i <= 1'b0;
      if (phase == 1) hold_req <= 1'b1;

      burst_left = 0;
      reach = int'(ring.outer);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // bursts with random gaps, some back to back
        if (burst_left == 0) begin
          gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if (gap_len != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap_len) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 32);
        end
        burst_left--;

        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          // raw noise over the full coordinate range
          offer_point(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
        end else begin
          base_x = int'($urandom_range(0, 56000)) - 28000;
          base_y = int'($urandom_range(0, 56000)) - 28000;
          if (sel == 1) begin
            // around the far-point cutoff
            dx = int'($urandom_range(0, 16383)) - 8192;
            dy = int'($urandom_range(0, 16383)) - 8192;
          end else begin
            // aim inside the ring
            tries = 0;
            do begin
              dx = int'($urandom_range(0, 2 * reach)) - reach;
              dy = int'($urandom_range(0, 2 * reach)) - reach;
              d2 = longint'(dx) * dx + longint'(dy) * dy;
              tries++;
            end while (tries < 16 &&
                       (d2 < longint'(ring.inner) * ring.inner ||
                        d2 > longint'(ring.outer) * ring.outer));
          end
          offer_point(16'(base_x), 16'(base_y), 16'(base_x + dx), 16'(base_y + dy), 1'b0);
        end
      end
    end

    // drain and finish
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_left <= $urandom_range(16, 128);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
        default:   out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    hit_result_t exp_r;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending: hit %0b segment %0d",
                 $time, hit_o, segment_index_o);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (hit_o !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, hit_o);
          mismatch_count++;
        end
        if (segment_index_o !== exp_r.segment) begin
          $display("%0t: segment_index expected %0d actual %0d",
                   $time, exp_r.segment, segment_index_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
